>>> src/assert_macros.svh
// assertion macros used by the table datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/krt_pkg.sv
// types and constants shared by the keyed record table modules
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

   localparam int OP_W     = 3;
   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 32;
   localparam int POS_W    = 4;
   localparam int CNT_W    = 5;
   localparam int STATUS_W = 2;
   localparam int REQ_W    = 72;
   localparam int RSP_W    = 72;

   localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT  = 3'd0,
      OP_LOOKUP  = 3'd1,
      OP_DELETE  = 3'd2,
      OP_MODIFY  = 3'd3,
      OP_READ_AT = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;
      logic       scan;
      logic       rd_pos;
      logic       sh_rd;
      logic       sh_wr;
      logic       wr_entry;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       res_set;
      logic       res_found;
      status_type res_status;
      logic       rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            pos_ok;
      logic            hit;
      logic            scan_done;
      logic            sh_more;
      logic            rsp_free;
   } sts_type;

endpackage

`default_nettype wire

>>> src/keyed_record_table_top.sv
// top level of the keyed record table: controller plus datapath
// full inserts and unused ops skip the scan, read-at reads its position directly,
//   and a delete moves every entry above the hit down one place
// throughput: one command at a time, next word taken once the result is registered
// the scan walks the entry memory one entry per cycle
// reset: count cleared, capacity back to 16, memory contents left as they are
`timescale 1ns / 1ps
`default_nettype none

module keyed_record_table_top
   import krt_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   // command words
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // op[2:0], key[34:3], record_handle[66:35],
                                              // position[70:67], zero pad
   // result words
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // status[1:0], found_key[33:2],
                                              // found_handle[65:34], entry_total[70:66], zero pad
   // capacity register write
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CNT_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // capacity writes are always taken
   assign csr_ready = 1'b1;

   // sequencer: one command from accept to result
   krt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // entry memory, search pointer, shift logic and result register
   krt_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wr     (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> src/krt_ctrl.sv
// command sequencer of the keyed record table
`timescale 1ns / 1ps
`default_nettype none

module krt_ctrl
   import krt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_DECODE  = 9'b000000010,
      S_SCAN    = 9'b000000100,
      S_RD_ISSU = 9'b000001000,
      S_RD_CAPT = 9'b000010000,
      S_SH_RD   = 9'b000100000,
      S_SH_WR   = 9'b001000000,
      S_WRITE   = 9'b010000000,
      S_DONE    = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_status = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.op)
               OP_INSERT: begin
                  if (sts.full) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_FULL;
                     state_in       = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               OP_LOOKUP, OP_DELETE, OP_MODIFY: begin
                  state_in = S_SCAN;
               end
               OP_READ_AT: begin
                  if (sts.pos_ok) begin
                     state_in = S_RD_ISSU;
                  end else begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_NOT_FOUND;
                     state_in       = S_DONE;
                  end
               end
               default: begin
                  // unused codes: plain ok, nothing changes
                  cmd.res_set = 1'b1;
                  state_in    = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               case (sts.op)
                  OP_INSERT: begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_DUPLICATE;
                     state_in       = S_DONE;
                  end
                  OP_LOOKUP: begin
                     cmd.res_set   = 1'b1;
                     cmd.res_found = 1'b1;
                     state_in      = S_DONE;
                  end
                  OP_DELETE: begin
                     state_in = S_SH_RD;
                  end
                  default: begin
                     state_in = S_WRITE;
                  end
               endcase
            end else if (sts.scan_done) begin
               if (sts.op == OP_INSERT) begin
                  state_in = S_WRITE;
               end else begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ST_NOT_FOUND;
                  state_in       = S_DONE;
               end
            end
         end
         S_RD_ISSU: begin
            cmd.rd_pos = 1'b1;
            state_in   = S_RD_CAPT;
         end
         S_RD_CAPT: begin
            cmd.res_set   = 1'b1;
            cmd.res_found = 1'b1;
            state_in      = S_DONE;
         end
         S_SH_RD: begin
            if (sts.sh_more) begin
               cmd.sh_rd = 1'b1;
               state_in  = S_SH_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               cmd.res_set = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_SH_WR: begin
            cmd.sh_wr = 1'b1;
            state_in  = S_SH_RD;
         end
         S_WRITE: begin
            cmd.wr_entry = 1'b1;
            cmd.cnt_inc  = (sts.op == OP_INSERT);
            cmd.res_set  = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> src/krt_dpath.sv
// entry memory, scan and shift datapath and result register of the table
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module krt_dpath
   import krt_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             csr_wr,
   input  wire logic [CNT_W-1:0] csr_data,
   input  wire cmd_type          cmd,
   output sts_type               sts,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata
);

   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = KEY_W + HANDLE_W;
   localparam int PAD_W   = RSP_W - (STATUS_W + KEY_W + HANDLE_W + CNT_W);

   logic [ENTRY_W-1:0] entry_mem [DEPTH];

   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    cap_ff, cap_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [CNT_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [ENTRY_W-1:0]  rdata_ff;
   status_type          res_status_ff, res_status_in;
   logic [KEY_W-1:0]    res_key_ff, res_key_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [KEY_W-1:0]   rd_key;
   logic [CNT_W-1:0]   ptr_next;
   logic               hit;

   assign rd_key   = rdata_ff[ENTRY_W-1 -: KEY_W];
   assign ptr_next = ptr_ff + 1'b1;
   assign hit      = pend_ff && (rd_key == key_ff);

   assign sts.op        = op_ff;
   assign sts.full      = (count_ff >= cap_ff) || (int'(count_ff) >= DEPTH);
   assign sts.pos_ok    = ({1'b0, pos_ff} < count_ff);
   assign sts.hit       = hit;
   assign sts.scan_done = !pend_ff && (idx_ff >= count_ff);
   assign sts.sh_more   = (({1'b0, ptr_ff} + 6'd1) < {1'b0, count_ff});
   assign sts.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      pos_in        = pos_ff;
      cap_in        = cap_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      ptr_in        = ptr_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = {key_ff, handle_ff};

      if (csr_wr) begin
         cap_in = csr_data;
      end

      if (cmd.latch) begin
         op_in     = req_tdata[OP_W-1:0];
         key_in    = req_tdata[OP_W +: KEY_W];
         handle_in = req_tdata[OP_W + KEY_W +: HANDLE_W];
         pos_in    = req_tdata[OP_W + KEY_W + HANDLE_W +: POS_W];
         idx_in    = '0;
         pend_in   = 1'b0;
      end

      // one read issued and one compared per cycle
      if (cmd.scan) begin
         pend_in = 1'b0;
         if (idx_ff < count_ff) begin
            rd_en       = 1'b1;
            rd_addr     = IDX_W'(idx_ff);
            idx_in      = idx_ff + 1'b1;
            pend_in     = 1'b1;
            pend_idx_in = idx_ff;
         end
         if (hit) begin
            ptr_in = pend_idx_ff;
         end
      end

      if (cmd.rd_pos) begin
         rd_en   = 1'b1;
         rd_addr = IDX_W'(pos_ff);
      end

      if (cmd.sh_rd) begin
         rd_en   = 1'b1;
         rd_addr = IDX_W'(ptr_next);
      end

      // move the entry above down one place
      if (cmd.sh_wr) begin
         wr_en   = 1'b1;
         wr_addr = IDX_W'(ptr_ff);
         wr_data = rdata_ff;
         ptr_in  = ptr_next;
      end

      if (cmd.wr_entry) begin
         wr_en   = 1'b1;
         wr_addr = (op_ff == OP_INSERT) ? IDX_W'(count_ff) : IDX_W'(ptr_ff);
      end

      if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end

      if (cmd.res_set) begin
         res_status_in = cmd.res_status;
         res_key_in    = cmd.res_found ? rd_key : '0;
         res_handle_in = cmd.res_found ? rdata_ff[HANDLE_W-1:0] : '0;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{PAD_W{1'b0}}, count_ff, res_handle_ff, res_key_ff, res_status_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_handle_ff <= res_handle_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, int'(count_ff) <= DEPTH, "entry count above depth")
   `ASSERT_IMPLIES(a_load_free, clock, reset, cmd.rsp_load, sts.rsp_free, "result overwritten")
   `ASSERT_IMPLIES(a_shift_range, clock, reset, cmd.sh_wr, sts.sh_more, "shift past last entry")
   `ASSERT_IMPLIES(a_insert_room, clock, reset, cmd.wr_entry && (op_ff == OP_INSERT), !sts.full,
      "insert into full table")

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for keyed_record_table_top: directed and random command words
`timescale 1ns / 1ps

module tb_top;
   import krt_pkg::*;

   localparam int TABLE_DEPTH    = 16;
   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 9;
   localparam int WATCHDOG_LIMIT = 3000;   // cycles with no word moving on any channel
   localparam int LONG_HOLD      = 300;    // receiver hold-off during the stall test
   localparam int SETTLE_CYCLES  = 64;     // longer than the slowest delete
   localparam int POOL_SIZE      = 20;     // a few more keys than the table holds

   // op codes the block leaves unused
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

   localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
   localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7fff_ffff;
   localparam logic [KEY_W-1:0] KEY_ONES = 32'hffff_ffff;

   // packed in tdata order: op in the lowest bits, position on top
   typedef struct packed {
      logic [POS_W-1:0]    pos;
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key;
      logic [OP_W-1:0]     op;
   } command_type;

   // packed in tdata order: status in the lowest bits, entry total on top
   typedef struct packed {
      logic [CNT_W-1:0]    total;
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key;
      status_type          status;
   } outcome_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data   = '0;

   // shadow copy of the table, updated when a command word is accepted
   logic [KEY_W-1:0]    shadow_keys    [TABLE_DEPTH];
   logic [HANDLE_W-1:0] shadow_handles [TABLE_DEPTH];
   int                  shadow_count    = 0;
   logic [CNT_W-1:0]    shadow_capacity = CAP_RESET;

   outcome_type      pending_results [$];   // oldest first
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   int send_idle_pct   = 36;
   int recv_idle_pct   = 65;
   bit long_hold_start = 1'b0;
   int error_count     = 0;

   keyed_record_table_top #(
      .DEPTH(TABLE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // index of the entry holding key, or the count when there is none
   function automatic int find_entry(input logic [KEY_W-1:0] key);
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_keys[i] == key) return i;
      end
      return shadow_count;
   endfunction

   // applies one command to the shadow table and returns the result word it gives
   function automatic outcome_type table_outcome(input command_type c);
      outcome_type res;
      int          idx;
      int          lim;
      res        = '0;
      res.status = ST_OK;
      // capacity above the table depth saturates
      lim = (shadow_capacity > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_capacity);
      idx = find_entry(c.key);
      case (c.op)
         OP_INSERT: begin
            // full wins over duplicate
            if (shadow_count >= lim) begin
               res.status = ST_FULL;
            end else if (idx < shadow_count) begin
               res.status = ST_DUPLICATE;
            end else begin
               shadow_keys[shadow_count]    = c.key;
               shadow_handles[shadow_count] = c.handle;
               shadow_count++;
            end
         end
         OP_LOOKUP: begin
            if (idx < shadow_count) begin
               res.key    = shadow_keys[idx];
               res.handle = shadow_handles[idx];
            end else begin
               res.status = ST_NOT_FOUND;
            end
         end
         OP_DELETE: begin
            // later entries move down one place so the table stays packed
            if (idx < shadow_count) begin
               for (int j = idx; j + 1 < shadow_count; j++) begin
                  shadow_keys[j]    = shadow_keys[j + 1];
                  shadow_handles[j] = shadow_handles[j + 1];
               end
               shadow_count--;
            end else begin
               res.status = ST_NOT_FOUND;
            end
         end
         OP_MODIFY: begin
            if (idx < shadow_count) shadow_handles[idx] = c.handle;
            else res.status = ST_NOT_FOUND;
         end
         OP_READ_AT: begin
            if (c.pos < shadow_count) begin
               res.key    = shadow_keys[c.pos];
               res.handle = shadow_handles[c.pos];
            end else begin
               res.status = ST_NOT_FOUND;
            end
         end
         default: begin
            // unused codes: ok status, nothing changes
         end
      endcase
      res.total = CNT_W'(shadow_count);
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic command_type cmd_word(input logic [OP_W-1:0] op,
                                            input logic [KEY_W-1:0] key,
                                            input logic [HANDLE_W-1:0] handle,
                                            input logic [POS_W-1:0] pos);
      command_type c;
      c.op     = op;
      c.key    = key;
      c.handle = handle;
      c.pos    = pos;
      return c;
   endfunction

   // mostly pool keys so that hits, duplicates and deletes happen often;
   // fill leans toward inserts, otherwise toward deletes
   function automatic command_type random_command(input bit fill);
      command_type c;
      int          roll;
      int          ins_w;
      int          del_w;
      ins_w = fill ? 50 : 22;
      del_w = fill ? 8 : 32;
      if ($urandom_range(99) < 85) c.key = key_pool[$urandom_range(POOL_SIZE - 1)];
      else c.key = $urandom;
      case ($urandom_range(9))
         0: c.handle = '0;
         1: c.handle = '1;
         default: c.handle = $urandom;
      endcase
      if ($urandom_range(1) == 0 || shadow_count == 0) c.pos = POS_W'($urandom);
      else c.pos = POS_W'($urandom_range(shadow_count - 1));
      roll = $urandom_range(99);
      if (roll < ins_w) c.op = OP_INSERT;
      else if (roll < ins_w + del_w) c.op = OP_DELETE;
      else if (roll < ins_w + del_w + 14) c.op = OP_LOOKUP;
      else if (roll < ins_w + del_w + 26) c.op = OP_MODIFY;
      else if (roll < 95) c.op = OP_READ_AT;
      else c.op = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      return c;
   endfunction

   // offers one command word and waits for it to be taken; valid stays high
   // afterwards so that back-to-back words need no second assignment
   task automatic issue_command(input command_type c);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, c};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(table_outcome(c));
   endtask

   // stops offering and waits until every pending result word is back
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // capacity is written only with the block idle
   task automatic write_capacity(input logic [CNT_W-1:0] value);
      wait_results_done();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      shadow_capacity = value;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // every op, key and handle extremes, duplicate, misses, shift on delete
   task automatic test_basic_ops();
      issue_command(cmd_word(OP_READ_AT, '0, '0, '0));              // empty table
      issue_command(cmd_word(OP_LOOKUP, KEY_MIN, '0, '0));
      issue_command(cmd_word(OP_INSERT, KEY_MIN, '0, '1));
      issue_command(cmd_word(OP_INSERT, KEY_MAX, '1, '0));
      issue_command(cmd_word(OP_INSERT, '0, 32'h1234_5678, '0));
      issue_command(cmd_word(OP_INSERT, KEY_ONES, 32'ha5a5_a5a5, '0));
      issue_command(cmd_word(OP_INSERT, KEY_MAX, 32'h0bad_cafe, '0)); // duplicate
      issue_command(cmd_word(OP_LOOKUP, '0, '0, '0));
      issue_command(cmd_word(OP_LOOKUP, 32'd5, '0, '0));
      issue_command(cmd_word(OP_MODIFY, KEY_ONES, 32'h5a5a_5a5a, '0));
      issue_command(cmd_word(OP_MODIFY, 32'd7, '1, '0));
      issue_command(cmd_word(OP_DELETE, KEY_MAX, '0, '0));             // middle entry
      for (int p = 0; p < 4; p++) begin
         issue_command(cmd_word(OP_READ_AT, '0, '0, POS_W'(p)));      // last one past count
      end
      issue_command(cmd_word(OP_READ_AT, '0, '0, '1));
      issue_command(cmd_word(OP_DELETE, 32'd9, '0, '0));
      for (int u = OP_UNUSED_FIRST; u <= OP_UNUSED_LAST; u++) begin
         issue_command(cmd_word(OP_W'(u), $urandom, $urandom, POS_W'($urandom)));
      end
      issue_command(cmd_word(OP_DELETE, KEY_MIN, '0, '0));             // first entry
   endtask

   // capacity zero and below the count, full before duplicate, saturation
   task automatic test_capacity_limits();
      write_capacity('0);
      issue_command(cmd_word(OP_INSERT, 32'h1357_2468, 32'd1, '0));
      issue_command(cmd_word(OP_INSERT, '0, 32'd2, '0));              // full and duplicate
      issue_command(cmd_word(OP_LOOKUP, KEY_ONES, '0, '0));            // entries kept
      issue_command(cmd_word(OP_DELETE, '0, '0, '0));
      write_capacity('1);
      issue_command(cmd_word(OP_INSERT, 32'h1357_2468, 32'd3, '0));
      issue_command(cmd_word(OP_INSERT, KEY_ONES, 32'd4, '0));
   endtask

   task automatic test_random_traffic(input logic [CNT_W-1:0] cap, input int send_pct,
                                      input int recv_pct, input int items);
      write_capacity(cap);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < items; i++) begin
         issue_command(random_command((i / 40) % 2 == 0));
      end
   endtask

   // receiver holds off while the sender keeps offering, so the input backs up
   task automatic test_output_stall();
      send_idle_pct   = 0;
      long_hold_start = 1'b1;
      for (int i = 0; i < 24; i++) begin
         issue_command(random_command(i < 16));
      end
      wait_results_done();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = '0;
      key_pool[3] = KEY_ONES;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sender 36, receiver 65 idle
      test_basic_ops();
      test_capacity_limits();
      test_random_traffic(5'd16, 36, 65, 230);
      test_output_stall();
      // sender 65, receiver 36; capacity above depth saturates
      test_random_traffic('1, 65, 36, 250);
      // no idling on either side
      test_random_traffic(5'd5, 0, 0, 100);
      test_random_traffic(5'd16, 0, 0, 120);

      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("keyed_record_table_top regression: pass");
      end else begin
         $display("keyed_record_table_top regression: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // random tready, or a long hold-off counted here when a test asks for one
   initial begin : rsp_ready_drive
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (long_hold_start) begin
            long_hold_start = 1'b0;
            hold            = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // each accepted result word against the oldest pending one, field by field
   always @(posedge clock) begin : check_results
      outcome_type want;
      outcome_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = outcome_type'(rsp_tdata[RSP_W-2:0]);
         if (pending_results.size() == 0) begin
            $error("result word with no command pending: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               error_count++;
            end
            if (got.key !== want.key) begin
               $error("found_key: expected %h, got %h", want.key, got.key);
               error_count++;
            end
            if (got.handle !== want.handle) begin
               $error("found_handle: expected %h, got %h", want.handle, got.handle);
               error_count++;
            end
            if (got.total !== want.total) begin
               $error("entry_total: expected %0d, got %0d", want.total, got.total);
               error_count++;
            end
         end
      end
   end

   // ends a hung run: too long with no word moving on any channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("keyed_record_table_top regression: fail");
      $finish;
   end

endmodule

>>> keyed_record_table_top.f
+incdir+src
src/krt_pkg.sv
src/krt_ctrl.sv
src/krt_dpath.sv
src/keyed_record_table_top.sv
dv/tb_top.sv
